@@ design/hecd_pkg.sv @@
// Package for the hex escape code point decoder.
// It holds the item types of both channels, the character constants and the digit helpers.
// It has no dependencies. The top level imports it.
package hecd_pkg;

    // One byte of escaped text.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } text_item_t;

    // One decoded character.
    typedef struct packed {
        logic [23:0] code_point;
        logic [3:0]  source_bytes;
        logic        last_of_run;
        logic        text_done;
    } code_item_t;

    localparam logic [7:0] CHAR_BACKSLASH = 8'd92;
    localparam logic [7:0] CHAR_COLON     = 8'd58;
    localparam logic [7:0] CHAR_ZERO      = 8'd48;
    localparam logic [7:0] CHAR_NINE      = 8'd57;
    localparam logic [7:0] CHAR_UPPER_A   = 8'd65;
    localparam logic [7:0] CHAR_UPPER_F   = 8'd70;
    // Subtracting this from 'A'..'F' gives the digit values 10..15.
    localparam logic [7:0] HEX_ALPHA_BIAS = 8'd55;

    localparam logic [3:0] PLAIN_BYTES  = 4'd1;
    localparam logic [3:0] ESCAPE_BYTES = 4'd8;
    localparam int         MAX_RUN      = 8;
    localparam int         ESC_DIGITS   = 6;

    // Rebuilds the upper-case hex character for a digit value.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, v};
        end
        else
        begin
            c = HEX_ALPHA_BIAS + {4'd0, v};
        end
        return c;
    endfunction

    // Picks one nibble of the digit accumulator, nibble 0 being the least significant.
    function automatic logic [3:0] acc_nibble(input logic [23:0] acc, input logic [2:0] idx);
        logic [3:0] n;
        case (idx)
            3'd0:    n = acc[3:0];
            3'd1:    n = acc[7:4];
            3'd2:    n = acc[11:8];
            3'd3:    n = acc[15:12];
            3'd4:    n = acc[19:16];
            3'd5:    n = acc[23:20];
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/hecd_chan_if.sv @@
// Valid/ready channel that carries one item per handshake.
// It depends on hecd_pkg only through the item type that an instance passes in.
interface hecd_chan_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/hex_escape_codepoint_decoder_unit.sv @@
// Hex escape code point decoder: turns text bytes into code points. A plain byte gives its own
// value. The sequence backslash, colon and six upper-case hex digits gives one code point with
// 8 source bytes. A broken or unfinished escape is given back as plain characters. A byte is
// accepted in every cycle while the result buffer is empty, or while it is sending its last
// result. A byte that flushes k held bytes gives up to k+1 results, one per cycle while the
// output is ready; they wait in the run buffer, and the next byte waits for the last of them.
// It depends on hecd_pkg and hecd_chan_if.
module hex_escape_codepoint_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    hecd_chan_if.sink          text_chan,
    hecd_chan_if.source        code_chan
);
    import hecd_pkg::*;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_SLASH  = 2'd1;
    localparam logic [1:0] MODE_DIGITS = 2'd2;

    // Parser state.
    logic [1:0]  mode_reg, mode_next;
    logic [2:0]  digits_reg, digits_next;
    logic [23:0] acc_reg, acc_next;

    // Run buffer: the results caused by the last accepted byte.
    logic [3:0]  rem_reg, rem_next;
    logic [2:0]  pos_reg, pos_next;
    logic        esc_reg, esc_next;
    logic [23:0] esc_cp_reg, esc_cp_next;
    logic        end_reg, end_next;
    logic [7:0]  run_reg [MAX_RUN];
    logic [7:0]  run_next [MAX_RUN];

    logic       in_fire, out_fire;
    logic [7:0] b;
    logic       eot;
    logic       is_hex;
    logic [3:0] val;
    logic [2:0] cnt;
    logic [3:0] nflush;
    logic       emit_cur;
    logic [3:0] nib_idx;

    assign b        = text_chan.payload.data_byte;
    assign eot      = text_chan.payload.end_of_text;
    assign out_fire = code_chan.valid && code_chan.ready;
    assign in_fire  = text_chan.valid && text_chan.ready;

    // A new byte may enter when the buffer will be empty after this cycle.
    assign text_chan.ready = (rem_reg == 4'd0) || (rem_reg == 4'd1 && code_chan.ready);

    // Result from the head of the run buffer.
    always_comb
    begin
        code_chan.valid = (rem_reg != 4'd0);
        if (esc_reg)
        begin
            code_chan.payload.code_point   = esc_cp_reg;
            code_chan.payload.source_bytes = ESCAPE_BYTES;
        end
        else
        begin
            code_chan.payload.code_point   = {16'd0, run_reg[pos_reg]};
            code_chan.payload.source_bytes = PLAIN_BYTES;
        end
        code_chan.payload.last_of_run = (rem_reg == 4'd1);
        code_chan.payload.text_done   = (rem_reg == 4'd1) && end_reg;
    end

    // Hex digit classification of the incoming byte.
    always_comb
    begin
        is_hex = 1'b0;
        val    = 4'd0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
        begin
            is_hex = 1'b1;
            val    = 4'(b - CHAR_ZERO);
        end
        else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F)
        begin
            is_hex = 1'b1;
            val    = 4'(b - HEX_ALPHA_BIAS);
        end
    end

    // Held bytes that a broken escape gives back, and where the current byte lands.
    always_comb
    begin
        cnt = (digits_reg > 3'd5) ? 3'd5 : digits_reg;
        if (mode_reg == MODE_SLASH)
        begin
            nflush = 4'd1;
        end
        else if (mode_reg == MODE_DIGITS)
        begin
            nflush = 4'd2 + {1'b0, cnt};
        end
        else
        begin
            nflush = 4'd0;
        end
        emit_cur = !(b == CHAR_BACKSLASH && !eot);
    end

    // Next state of the parser and of the run buffer.
    always_comb
    begin
        mode_next   = mode_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        esc_next    = esc_reg;
        esc_cp_next = esc_cp_reg;
        end_next    = end_reg;
        nib_idx     = 4'd0;
        for (int k = 0; k < MAX_RUN; k++)
        begin
            run_next[k] = run_reg[k];
        end

        // Drain one result.
        if (out_fire)
        begin
            rem_next = rem_reg - 4'd1;
            pos_next = pos_reg + 3'd1;
        end

        if (in_fire)
        begin
            pos_next = 3'd0;
            end_next = eot;
            esc_next = 1'b0;
            rem_next = 4'd0;
            if (mode_reg == MODE_DIGITS && is_hex && digits_reg >= 3'(ESC_DIGITS - 1))
            begin
                // Sixth digit completes the escape.
                esc_next    = 1'b1;
                esc_cp_next = {acc_reg[19:0], val};
                rem_next    = 4'd1;
                mode_next   = MODE_IDLE;
                digits_next = 3'd0;
                acc_next    = 24'd0;
            end
            else if (mode_reg == MODE_DIGITS && is_hex && !eot)
            begin
                acc_next    = {acc_reg[19:0], val};
                digits_next = digits_reg + 3'd1;
            end
            else if (mode_reg == MODE_SLASH && b == CHAR_COLON && !eot)
            begin
                mode_next   = MODE_DIGITS;
                digits_next = 3'd0;
                acc_next    = 24'd0;
            end
            else
            begin
                // Give back the held bytes, then take the current byte afresh.
                for (int k = 0; k < MAX_RUN; k++)
                begin
                    nib_idx = {1'b0, cnt} + 4'd1 - 4'(k);
                    if (4'(k) == nflush)
                    begin
                        run_next[k] = b;
                    end
                    else if (k == 0)
                    begin
                        run_next[k] = CHAR_BACKSLASH;
                    end
                    else if (k == 1)
                    begin
                        run_next[k] = CHAR_COLON;
                    end
                    else
                    begin
                        run_next[k] = hex_char(acc_nibble(acc_reg, nib_idx[2:0]));
                    end
                end
                rem_next    = nflush + {3'd0, emit_cur};
                digits_next = 3'd0;
                acc_next    = 24'd0;
                mode_next   = emit_cur ? MODE_IDLE : MODE_SLASH;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            digits_reg <= 3'd0;
            acc_reg    <= 24'd0;
            rem_reg    <= 4'd0;
            pos_reg    <= 3'd0;
            esc_reg    <= 1'b0;
            end_reg    <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            esc_reg    <= esc_next;
            end_reg    <= end_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        esc_cp_reg <= esc_cp_next;
        for (int k = 0; k < MAX_RUN; k++)
        begin
            run_reg[k] <= run_next[k];
        end
    end

    // A run never holds more than a full flush plus the current byte.
    assert property (@(posedge clk) disable iff (!rst_n) rem_reg <= 4'(MAX_RUN))
        else $error("run buffer count out of range");

    // No byte is taken while two or more results of the previous one remain.
    assert property (@(posedge clk) disable iff (!rst_n) rem_reg > 4'd1 |-> !text_chan.ready)
        else $error("byte accepted over a pending run");

    // A completed escape is always a run of one result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (esc_reg && rem_reg != 4'd0) |-> rem_reg == 4'd1)
        else $error("escape result inside a longer run");

    // Outside digit gathering no digits are held.
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_DIGITS |-> (digits_reg == 3'd0 && acc_reg == 24'd0))
        else $error("digits held outside an escape");

    // An escape that has just completed leaves the parser idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode_reg == MODE_DIGITS && is_hex && digits_reg == 3'd5)
        |=> (mode_reg == MODE_IDLE && esc_reg && rem_reg == 4'd1))
        else $error("escape completion did not return to idle");

endmodule
